### hdl/mac_pkg.sv
package mac_pkg;

   // supply classes, in millivolts
   localparam logic [12:0] MV_CHARGING = 13'd4000;
   localparam logic [12:0] MV_FULL     = 13'd3700;
   localparam logic [12:0] MV_HALF     = 13'd3500;

   localparam logic [8:0]  TILT_THRESHOLD_RESET = 9'd20;
   localparam logic [10:0] RATE_THRESHOLD_RESET = 11'd50;

   localparam int unsigned CSR_DATA_W = 11;
   localparam logic CSR_TILT_THRESHOLD = 1'b0;
   localparam logic CSR_RATE_THRESHOLD = 1'b1;

   localparam logic [7:0] WAKE_COUNT_MAX = 8'd255;

   localparam logic [1:0] POWER_EXTERNAL = 2'd0;
   localparam logic [1:0] POWER_FULL     = 2'd1;
   localparam logic [1:0] POWER_HALF     = 2'd2;
   localparam logic [1:0] POWER_LOW      = 2'd3;

   localparam logic [2:0] LED_OFF    = 3'd0;
   localparam logic [2:0] LED_RED    = 3'd1;
   localparam logic [2:0] LED_GREEN  = 3'd2;
   localparam logic [2:0] LED_BLUE   = 3'd3;
   localparam logic [2:0] LED_YELLOW = 3'd4;
   localparam logic [2:0] LED_VIOLET = 3'd5;
   localparam logic [2:0] LED_NAVY   = 3'd6;

   localparam logic [1:0] TONE_OFF    = 2'd0;
   localparam logic [1:0] TONE_HORN   = 2'd1;
   localparam logic [1:0] TONE_CHIRP  = 2'd2;
   localparam logic [1:0] TONE_MELODY = 2'd3;

   localparam logic [1:0] ALERT_CLEAR  = 2'd0;
   localparam logic [1:0] ALERT_MOTION = 2'd1;
   localparam logic [1:0] ALERT_TAMPER = 2'd2;

   localparam logic [1:0] WAKE_NONE = 2'd0;
   localparam logic [1:0] WAKE_1S   = 2'd1;
   localparam logic [1:0] WAKE_4S   = 2'd2;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 16;

   typedef struct packed {
      logic               mode_switch;
      logic               horn_button;
      logic               short_button;
      logic               long_button;
      logic [12:0]        supply_mv;
      logic signed [8:0]  tilt_x;
      logic signed [8:0]  tilt_y;
      logic signed [8:0]  tilt_z;
      logic signed [11:0] rate_x;
      logic signed [11:0] rate_y;
      logic signed [11:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [1:0] power_status;
      logic [2:0] led_color;
      logic [1:0] sound_select;
      logic [1:0] alarm_status;
      logic       sensors_powered;
      logic       sleep_request;
      logic [1:0] wake_timer;
   } rsp_type;

endpackage

### hdl/mac_core.sv
module mac_core import mac_pkg::*; #(
   parameter int unsigned MAX_WAKEUPS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  req_type     item,
   input  logic [8:0]  tilt_threshold,
   input  logic [10:0] rate_threshold,
   output rsp_type     result
);

   function automatic logic [9:0] tilt_mag(input logic signed [8:0] a,
                                           input logic signed [8:0] b);
      logic signed [9:0] d;
      d = 10'(a) - 10'(b);
      return d[9] ? 10'(-d) : 10'(d);
   endfunction

   function automatic logic [11:0] rate_mag(input logic signed [11:0] r);
      return r[11] ? 12'(-r) : 12'(r);
   endfunction

   logic              security_mode_ff, security_mode_in;
   logic              baseline_valid_ff, baseline_valid_in;
   logic [1:0]        alarm_state_ff, alarm_state_in;
   logic [7:0]        wake_count_ff, wake_count_in;
   logic signed [8:0] base_x_ff, base_x_in;
   logic signed [8:0] base_y_ff, base_y_in;
   logic signed [8:0] base_z_ff, base_z_in;
   logic [2:0]        led_hold_ff, led_hold_in;
   logic [3:0]        last_inputs_ff, last_inputs_in;

   logic [3:0] changed;
   logic [7:0] wc;
   logic [1:0] power;
   logic [2:0] color;
   logic [1:0] sound;
   logic       sleep;
   logic [1:0] timer;
   logic       capture;
   logic       tilt_hit;
   logic       rate_hit;

   always_comb begin
      last_inputs_in = {item.long_button, item.short_button, item.horn_button,
                        item.mode_switch};
      changed = last_inputs_in ^ last_inputs_ff;

      // buttons only count while the previous pass was in drive mode
      wc = wake_count_ff;
      if (changed[0] || ((|changed[3:1]) && !security_mode_ff)) begin
         wc = '0;
      end

      if (item.supply_mv >= MV_CHARGING) begin
         power = POWER_EXTERNAL;
         color = LED_VIOLET;
         wc    = '0;
      end else if (item.supply_mv > MV_FULL) begin
         power = POWER_FULL;
         color = LED_GREEN;
      end else if (item.supply_mv > MV_HALF) begin
         power = POWER_HALF;
         color = LED_BLUE;
      end else begin
         power = POWER_LOW;
         color = LED_RED;
      end

      security_mode_in  = security_mode_ff;
      baseline_valid_in = baseline_valid_ff;
      alarm_state_in    = alarm_state_ff;
      base_x_in         = base_x_ff;
      base_y_in         = base_y_ff;
      base_z_in         = base_z_ff;
      led_hold_in       = led_hold_ff;
      sound             = TONE_OFF;
      sleep             = 1'b0;
      timer             = WAKE_NONE;
      wake_count_in     = wc;
      capture           = 1'b0;
      tilt_hit          = 1'b0;
      rate_hit          = 1'b0;

      if (!item.mode_switch) begin
         if (security_mode_ff) begin
            baseline_valid_in = 1'b0;
         end
         security_mode_in = 1'b0;
         if (item.horn_button) begin
            sound = TONE_HORN;
         end else if (item.short_button) begin
            sound = TONE_CHIRP;
         end else if (item.long_button) begin
            sound = TONE_MELODY;
         end
         if (sound == TONE_OFF) begin
            led_hold_in = color;
            if (power != POWER_EXTERNAL) begin
               sleep = 1'b1;
               timer = (wc < 8'(MAX_WAKEUPS)) ? WAKE_4S : WAKE_NONE;
               if (wc != WAKE_COUNT_MAX) begin
                  wake_count_in = wc + 8'd1;
               end
            end
         end
      end else begin
         // new baseline on arming or right after a siren
         capture = !security_mode_ff || (alarm_state_ff == ALERT_TAMPER);
         if (capture) begin
            base_x_in         = item.tilt_x;
            base_y_in         = item.tilt_y;
            base_z_in         = item.tilt_z;
            baseline_valid_in = 1'b1;
         end
         security_mode_in = 1'b1;
         led_hold_in      = LED_NAVY;
         alarm_state_in   = ALERT_CLEAR;
         tilt_hit = (tilt_mag(base_x_in, item.tilt_x) > {1'b0, tilt_threshold})
                 || (tilt_mag(base_y_in, item.tilt_y) > {1'b0, tilt_threshold})
                 || (tilt_mag(base_z_in, item.tilt_z) > {1'b0, tilt_threshold});
         rate_hit = (rate_mag(item.rate_x) > {1'b0, rate_threshold})
                 || (rate_mag(item.rate_y) > {1'b0, rate_threshold})
                 || (rate_mag(item.rate_z) > {1'b0, rate_threshold});
         if (baseline_valid_in) begin
            if (tilt_hit) begin
               alarm_state_in = ALERT_TAMPER;
               led_hold_in    = LED_RED;
            end else if (rate_hit) begin
               alarm_state_in = ALERT_MOTION;
               led_hold_in    = LED_YELLOW;
            end
         end
         if (alarm_state_in == ALERT_CLEAR && power != POWER_EXTERNAL) begin
            sleep = 1'b1;
            timer = WAKE_1S;
            if (wc != WAKE_COUNT_MAX) begin
               wake_count_in = wc + 8'd1;
            end
         end
      end

      result.power_status    = power;
      result.led_color       = led_hold_in;
      result.sound_select    = sound;
      result.alarm_status    = alarm_state_in;
      result.sensors_powered = security_mode_in;
      result.sleep_request   = sleep;
      result.wake_timer      = timer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         security_mode_ff  <= 1'b0;
         baseline_valid_ff <= 1'b0;
         alarm_state_ff    <= ALERT_CLEAR;
         wake_count_ff     <= '0;
         base_x_ff         <= '0;
         base_y_ff         <= '0;
         base_z_ff         <= '0;
         led_hold_ff       <= LED_OFF;
         last_inputs_ff    <= '0;
      end else if (fire) begin
         security_mode_ff  <= security_mode_in;
         baseline_valid_ff <= baseline_valid_in;
         alarm_state_ff    <= alarm_state_in;
         wake_count_ff     <= wake_count_in;
         base_x_ff         <= base_x_in;
         base_y_ff         <= base_y_in;
         base_z_ff         <= base_z_in;
         led_hold_ff       <= led_hold_in;
         last_inputs_ff    <= last_inputs_in;
      end
   end

endmodule

### hdl/motion_alarm_controller.sv
// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   req_tdata  : one pass of the alarm loop
// rsp_      out        rsp_tvalid / rsp_tready   rsp_tdata  : one result per item
// csr_      in         csr_we                    csr_index, csr_wdata : thresholds
//
// One item per cycle sustained while rsp_ is ready; each item passes the input
// register, then the alarm logic feeding a two-entry result queue.
// The queue decouples the sides: req_tready depends only on local registers.
// Reset is synchronous and returns thresholds and alarm state to defaults.
// A stalled rsp_ side fills the queue, then the input register, then holds req_.
module motion_alarm_controller import mac_pkg::*; #(
   parameter int unsigned MAX_WAKEUPS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode_switch, horn_button, short_button, long_button, supply_mv,
   // tilt_x, tilt_y, tilt_z, rate_x, rate_y, rate_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // power_status, led_color, sound_select, alarm_status, sensors_powered,
   // sleep_request, wake_timer, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [8:0]  tilt_threshold_ff;
   logic [10:0] rate_threshold_ff;

   req_type item_in;
   req_type item_ff;
   logic    item_valid_ff;

   rsp_type result;
   rsp_type head_ff, head_in;
   rsp_type tail_ff, tail_in;
   logic    head_valid_ff, head_valid_in;
   logic    tail_valid_ff, tail_valid_in;

   logic fire;
   logic pop;

   always_comb begin
      item_in.mode_switch  = req_tdata[0];
      item_in.horn_button  = req_tdata[1];
      item_in.short_button = req_tdata[2];
      item_in.long_button  = req_tdata[3];
      item_in.supply_mv    = req_tdata[16:4];
      item_in.tilt_x       = req_tdata[25:17];
      item_in.tilt_y       = req_tdata[34:26];
      item_in.tilt_z       = req_tdata[43:35];
      item_in.rate_x       = req_tdata[55:44];
      item_in.rate_y       = req_tdata[67:56];
      item_in.rate_z       = req_tdata[79:68];
   end

   // queue has room unless both entries are full
   assign fire       = item_valid_ff && !tail_valid_ff;
   assign req_tready = !item_valid_ff || fire;
   assign pop        = head_valid_ff && rsp_tready;

   mac_core #(
      .MAX_WAKEUPS (MAX_WAKEUPS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (item_ff),
      .tilt_threshold (tilt_threshold_ff),
      .rate_threshold (rate_threshold_ff),
      .result         (result)
   );

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
      if (fire) begin
         if (!head_valid_in) begin
            head_in       = result;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = result;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         head_valid_ff     <= 1'b0;
         tail_valid_ff     <= 1'b0;
         tilt_threshold_ff <= TILT_THRESHOLD_RESET;
         rate_threshold_ff <= RATE_THRESHOLD_RESET;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TILT_THRESHOLD: tilt_threshold_ff <= csr_wdata[8:0];
               CSR_RATE_THRESHOLD: rate_threshold_ff <= csr_wdata[10:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {3'b000, head_ff.wake_timer, head_ff.sleep_request,
                        head_ff.sensors_powered, head_ff.alarm_status,
                        head_ff.sound_select, head_ff.led_color,
                        head_ff.power_status};

endmodule

### bench/alarm_pass_checker.sv
`timescale 1ns / 100ps

module alarm_pass_checker import mac_pkg::*; #(
   parameter int unsigned MAX_WAKEUPS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    failures
);

   int         tilt_limit;
   int         rate_limit;
   logic       in_security;
   logic       baseline_ok;
   logic [1:0] alarm_held;
   logic [7:0] wakes;
   int         base_x, base_y, base_z;
   logic [2:0] led_held;
   logic [3:0] prev_controls;
   int         mismatch_count = 0;
   rsp_type    expected_outputs[$];

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void count_wake();
      if (wakes != WAKE_COUNT_MAX)
         wakes++;
   endfunction

   // One pass of the alarm loop: updates the mirrored state, returns the outputs.
   function automatic rsp_type predict_pass(input logic [REQ_DATA_W-1:0] d);
      rsp_type    r;
      logic       sw, horn, shrt, lng;
      logic [12:0] mv;
      int         tx, ty, tz, rx, ry, rz;
      logic [3:0] now, changed;
      logic [2:0] color;
      sw   = d[0];
      horn = d[1];
      shrt = d[2];
      lng  = d[3];
      mv   = d[16:4];
      tx = $signed(d[25:17]);
      ty = $signed(d[34:26]);
      tz = $signed(d[43:35]);
      rx = $signed(d[55:44]);
      ry = $signed(d[67:56]);
      rz = $signed(d[79:68]);
      r = '0;
      r.sound_select = TONE_OFF;
      r.wake_timer = WAKE_NONE;

      now = {lng, shrt, horn, sw};
      changed = now ^ prev_controls;
      // buttons only count while the previous pass was in drive mode
      if (changed[0] || (changed[3:1] != 3'b000 && !in_security))
         wakes = '0;
      prev_controls = now;

      if (mv >= MV_CHARGING) begin
         r.power_status = POWER_EXTERNAL;
         color = LED_VIOLET;
         wakes = '0;
      end else if (mv > MV_FULL) begin
         r.power_status = POWER_FULL;
         color = LED_GREEN;
      end else if (mv > MV_HALF) begin
         r.power_status = POWER_HALF;
         color = LED_BLUE;
      end else begin
         r.power_status = POWER_LOW;
         color = LED_RED;
      end

      if (!sw) begin
         if (in_security)
            baseline_ok = 1'b0;
         in_security = 1'b0;
         if (horn)
            r.sound_select = TONE_HORN;
         else if (shrt)
            r.sound_select = TONE_CHIRP;
         else if (lng)
            r.sound_select = TONE_MELODY;
         if (r.sound_select == TONE_OFF) begin
            led_held = color;
            if (r.power_status != POWER_EXTERNAL) begin
               r.sleep_request = 1'b1;
               r.wake_timer = (wakes < MAX_WAKEUPS) ? WAKE_4S : WAKE_NONE;
               count_wake();
            end
         end
      end else begin
         if (!in_security || alarm_held == ALERT_TAMPER) begin
            base_x = tx;
            base_y = ty;
            base_z = tz;
            baseline_ok = 1'b1;
         end
         in_security = 1'b1;
         led_held = LED_NAVY;
         alarm_held = ALERT_CLEAR;
         if (baseline_ok) begin
            if (magnitude(base_x - tx) > tilt_limit || magnitude(base_y - ty) > tilt_limit ||
                magnitude(base_z - tz) > tilt_limit) begin
               alarm_held = ALERT_TAMPER;
               led_held = LED_RED;
            end else if (magnitude(rx) > rate_limit || magnitude(ry) > rate_limit ||
                         magnitude(rz) > rate_limit) begin
               alarm_held = ALERT_MOTION;
               led_held = LED_YELLOW;
            end
         end
         if (alarm_held == ALERT_CLEAR && r.power_status != POWER_EXTERNAL) begin
            r.sleep_request = 1'b1;
            r.wake_timer = WAKE_1S;
            count_wake();
         end
      end

      r.led_color = led_held;
      r.alarm_status = alarm_held;
      r.sensors_powered = in_security;
      return r;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result(rsp_type want, logic [RSP_DATA_W-1:0] got);
      compare_field("power_status", want.power_status, got[1:0]);
      compare_field("led_color", want.led_color, got[4:2]);
      compare_field("sound_select", want.sound_select, got[6:5]);
      compare_field("alarm_status", want.alarm_status, got[8:7]);
      compare_field("sensors_powered", want.sensors_powered, got[9]);
      compare_field("sleep_request", want.sleep_request, got[10]);
      compare_field("wake_timer", want.wake_timer, got[12:11]);
      compare_field("zero fill", 0, got[RSP_DATA_W-1:13]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tilt_limit = TILT_THRESHOLD_RESET;
         rate_limit = RATE_THRESHOLD_RESET;
         in_security = 1'b0;
         baseline_ok = 1'b0;
         alarm_held = ALERT_CLEAR;
         wakes = '0;
         base_x = 0;
         base_y = 0;
         base_z = 0;
         led_held = LED_OFF;
         prev_controls = '0;
         expected_outputs.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_outputs.push_back(predict_pass(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               $error("result item with no item pending");
               mismatch_count++;
            end else begin
               check_result(expected_outputs.pop_front(), rsp_tdata);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_TILT_THRESHOLD)
               tilt_limit = csr_wdata[8:0];
            else
               rate_limit = csr_wdata[10:0];
         end
      end
      outstanding <= expected_outputs.size();
      failures <= mismatch_count;
   end

endmodule

### bench/motion_alarm_controller_test.sv
`timescale 1ns / 100ps

module motion_alarm_controller_test;
   import mac_pkg::*;

   localparam int unsigned WAKE_LIMIT      = 10;
   localparam int unsigned LONG_HOLD       = 200;
   localparam int unsigned WATCHDOG_CYCLES = 5000;
   localparam int unsigned DRAIN_CYCLES    = 10;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   outstanding;
   int   failures;
   int   sender_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_go = 1'b0;
   int   hold_left = 0;
   int   idle_cycles = 0;
   int   tilt_thr;
   int   rate_thr;

   always #5 clock = ~clock;

   motion_alarm_controller #(
      .MAX_WAKEUPS (WAKE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   alarm_pass_checker #(
      .MAX_WAKEUPS (WAKE_LIMIT)
   ) response_check (.*);

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("** motion_alarm_controller: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pass_bits(bit sw, bit horn, bit shrt, bit lng,
         int mv, int tx, int ty, int tz, int rx, int ry, int rz);
      return {rz[11:0], ry[11:0], rx[11:0], tz[8:0], ty[8:0], tx[8:0], mv[12:0],
              lng, shrt, horn, sw};
   endfunction

   function automatic int pick_supply();
      case ($urandom_range(11))
         0: return 0;
         1: return 3500;
         2: return 3501;
         3: return 3700;
         4: return 3701;
         5: return 3999;
         6: return 4000;
         7: return 8191;
         8: return $urandom_range(8191);
         default: return $urandom_range(3000, 4100);
      endcase
   endfunction

   function automatic int near_edge(int thr);
      case ($urandom_range(5))
         0: return thr;
         1: return thr + 1;
         2: return -thr;
         3: return -thr - 1;
         default: return int'($urandom_range(2 * thr + 2)) - thr - 1;
      endcase
   endfunction

   function automatic int jitter(int thr);
      if ($urandom_range(3) == 0)
         return near_edge(thr);
      return int'($urandom_range(thr)) - thr / 2;
   endfunction

   function automatic int any_tilt();
      return int'($urandom_range(511)) - 256;
   endfunction

   function automatic int any_rate();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   task automatic send_item(input logic [REQ_DATA_W-1:0] d);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // both registers, back to back; only called with nothing in flight
   task automatic set_thresholds(int tilt_w, int rate_w);
      tilt_thr = tilt_w & 'h1FF;
      rate_thr = rate_w & 'h7FF;
      csr_we <= 1'b1;
      csr_index <= CSR_TILT_THRESHOLD;
      csr_wdata <= tilt_w[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_RATE_THRESHOLD;
      csr_wdata <= rate_w[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // constant inputs, no alarm, not charging: the wake count climbs
   task automatic run_quiet(int len);
      bit         sw;
      logic [2:0] btn;
      int         mv, tx, ty, tz;
      sw = $urandom_range(1);
      btn = sw ? 3'($urandom_range(7)) : 3'b000;
      mv = $urandom_range(3999);
      tx = any_tilt();
      ty = any_tilt();
      tz = any_tilt();
      repeat (len)
         send_item(pass_bits(sw, btn[0], btn[1], btn[2], mv, tx, ty, tz, 0, 0, 0));
   endtask

   task automatic run_random(int n);
      int          done;
      int          len;
      int          kind;
      int          bx, by, bz, mv;
      logic [2:0]  btn;
      logic [95:0] raw;
      done = 0;
      while (done < n) begin
         kind = $urandom_range(9);
         len = $urandom_range(4, 30);
         bx = int'($urandom_range(360)) - 180;
         by = int'($urandom_range(360)) - 180;
         bz = int'($urandom_range(360)) - 180;
         btn = ($urandom_range(2) == 0) ? 3'($urandom_range(7)) : 3'b000;
         mv = pick_supply();
         if (kind == 9) begin
            run_quiet(len);
         end else begin
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(5) == 0)
                  btn = 3'($urandom_range(7));
               if ($urandom_range(3) == 0)
                  mv = pick_supply();
               if (kind < 4) begin
                  send_item(pass_bits(1'b0, btn[0], btn[1], btn[2], mv, any_tilt(),
                                      any_tilt(), any_tilt(), any_rate(), any_rate(),
                                      any_rate()));
               end else if (kind < 8) begin
                  // armed: tilts around a baseline, rates around the threshold,
                  // the odd disarm in between
                  send_item(pass_bits($urandom_range(19) != 0, btn[0], btn[1], btn[2], mv,
                                      bx + jitter(tilt_thr), by + jitter(tilt_thr),
                                      bz + jitter(tilt_thr), jitter(rate_thr),
                                      jitter(rate_thr), jitter(rate_thr)));
               end else begin
                  raw = {$urandom(), $urandom(), $urandom()};
                  send_item(raw[REQ_DATA_W-1:0]);
               end
            end
         end
         done += len;
      end
   endtask

   task automatic run_directed();
      send_item(pass_bits(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(pass_bits(0, 1, 1, 1, 3501, 0, 0, 0, 0, 0, 0));
      send_item(pass_bits(0, 0, 1, 1, 3701, 0, 0, 0, 0, 0, 0));
      send_item(pass_bits(0, 0, 0, 1, 4000, 0, 0, 0, 0, 0, 0));
      send_item(pass_bits(0, 0, 0, 0, 8191, 0, 0, 0, 0, 0, 0));
      send_item(pass_bits(0, 0, 0, 0, 3700, 0, 0, 0, 0, 0, 0));
      // arming captures the baseline
      send_item(pass_bits(1, 0, 0, 0, 3800, 10, -10, 0, 0, 0, 0));
      send_item(pass_bits(1, 0, 0, 0, 3800, 10, -10, 0, 51, 0, 0));
      send_item(pass_bits(1, 0, 0, 0, 3800, 10, -10, 0, 0, -51, 50));
      send_item(pass_bits(1, 0, 0, 0, 3800, 31, -30, 0, 0, 0, 0));
      // recapture after the siren, then a warning and another siren
      send_item(pass_bits(1, 1, 0, 0, 3800, -256, 255, -20, -2048, 0, 0));
      send_item(pass_bits(1, 1, 1, 1, 4000, -256, 255, -41, 0, 0, 2047));
      send_item(pass_bits(1, 0, 0, 0, 3800, -256, 255, 0, 0, 0, 0));
      send_item(pass_bits(1, 0, 0, 0, 3500, -236, 235, 20, 50, -50, 0));
      // back to drive, then past the wake limit
      repeat (12)
         send_item(pass_bits(0, 0, 0, 0, 3600, any_tilt(), any_tilt(), any_tilt(),
                             any_rate(), any_rate(), any_rate()));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_TILT_THRESHOLD;
      csr_wdata = '0;
      tilt_thr = TILT_THRESHOLD_RESET;
      rate_thr = RATE_THRESHOLD_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      settle();
      set_thresholds(0, 0);
      run_random(200);

      settle();
      set_thresholds(360, 2000);
      sender_idle_pct = 86;
      run_random(200);

      settle();
      set_thresholds(2047, 2047);
      sender_idle_pct = 0;
      stall_pct <= 86;
      run_random(200);

      settle();
      set_thresholds(15, 300);
      sender_idle_pct = 22;
      stall_pct <= 22;
      run_random(250);

      // receiver holds off while items keep coming
      sender_idle_pct = 0;
      stall_pct <= 0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      run_random(40);

      settle();
      set_thresholds($urandom_range(1, 100), $urandom_range(1, 400));
      run_quiet(270);
      run_random(250);

      settle();
      set_thresholds(5, 25);
      sender_idle_pct = 22;
      stall_pct <= 22;
      run_random(250);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("** motion_alarm_controller: PASSED **");
      else
         $display("** motion_alarm_controller: FAILED **");
      $finish;
   end

endmodule

### filelist.f
hdl/mac_pkg.sv
hdl/mac_core.sv
hdl/motion_alarm_controller.sv
bench/alarm_pass_checker.sv
bench/motion_alarm_controller_test.sv
